>>> hdl/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion core
// no dependencies
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int DATA_W = 16;
   localparam int RAD_W = 32;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SQ_REM_W = ROOT_W + 3;
   localparam int MAG_W = DATA_W + 1;
   localparam int BIG_W = ROOT_W - 1;
   localparam int DVD_W = MAG_W + FRAC_BITS - 2;
   localparam int LANES = 3;

   localparam logic [1:0] COMP_W = 2'd0;
   localparam logic [1:0] COMP_X = 2'd1;
   localparam logic [1:0] COMP_Y = 2'd2;
   localparam logic [1:0] COMP_Z = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_w;
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic [1:0] largest_component;
   } rsp_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0] rad;
   } sq_type;

   typedef struct packed {
      logic [BIG_W-1:0] rem;
      logic [DVD_W-1:0] dq;
   } dv_type;

   typedef struct packed {
      logic [1:0] idx;
      logic [LANES-1:0] neg;
      logic [LANES-1:0][MAG_W-1:0] mag;
   } sq_side_type;

   typedef struct packed {
      logic [1:0] idx;
      logic [LANES-1:0] neg;
      logic [BIG_W-1:0] big;
   } dv_side_type;

endpackage

>>> hdl/rmq_sqrt_cell.sv
// one step of the square root chain, one root bit per cell
// depends on rmq_pkg
module rmq_sqrt_cell (
   input  logic clock,
   input  logic enable,
   input  rmq_pkg::sq_type cell_i,
   output rmq_pkg::sq_type cell_ff
);
   import rmq_pkg::*;

   logic [SQ_REM_W-1:0] rem2;
   logic [SQ_REM_W-1:0] trial;
   sq_type cell_in;

   always_comb begin
      rem2 = {cell_i.rem[SQ_REM_W-3:0], cell_i.rad[RAD_W-1 -: 2]};
      trial = {1'b0, cell_i.root, 2'b01};
      cell_in.rad = {cell_i.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         cell_in.rem = rem2 - trial;
         cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_in.rem = rem2;
         cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end
endmodule

>>> hdl/rmq_div_cell.sv
// one step of the restoring divider chain, one quotient bit per cell
// depends on rmq_pkg
module rmq_div_cell (
   input  logic clock,
   input  logic enable,
   input  logic [rmq_pkg::BIG_W-1:0] divisor,
   input  rmq_pkg::dv_type cell_i,
   output rmq_pkg::dv_type cell_ff
);
   import rmq_pkg::*;

   logic [BIG_W:0] rem2;
   logic ge;
   dv_type cell_in;

   always_comb begin
      rem2 = {cell_i.rem, cell_i.dq[DVD_W-1]};
      ge = rem2 >= {1'b0, divisor};
      cell_in.dq = {cell_i.dq[DVD_W-2:0], ge};
      if (ge) begin
         cell_in.rem = BIG_W'(rem2 - {1'b0, divisor});
      end else begin
         cell_in.rem = rem2[BIG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end
endmodule

>>> hdl/rotation_matrix_to_quaternion_core.sv
// rotation matrix to quaternion, largest component method
// pipeline: front stage, 16 square root cells, divider load, 29 divider cells, output register
// throughput: one transfer per cycle; the whole chain holds while a result is stalled
// reset clears all valid bits; data registers are not reset
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell
module rotation_matrix_to_quaternion_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  rmq_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rmq_pkg::rsp_type rsp_payload
);
   import rmq_pkg::*;

   localparam int SQ_N = ROOT_W;
   localparam int DV_N = DVD_W;

   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // front stage
   logic signed [DATA_W+1:0] comb [4];
   logic signed [DATA_W+1:0] best;
   logic [1:0] idx;
   logic signed [MAG_W-1:0] dlane [LANES];
   logic signed [MAG_W-1:0] d_a, d_b, d_c, s_a, s_b, s_c;
   logic [DATA_W+1:0] rsum;
   sq_type sq_in;
   sq_side_type side_in;

   always_comb begin
      comb[0] = 18'(req_payload.m00) + 18'(req_payload.m11) + 18'(req_payload.m22);
      comb[1] = 18'(req_payload.m00) - 18'(req_payload.m11) - 18'(req_payload.m22);
      comb[2] = 18'(req_payload.m11) - 18'(req_payload.m00) - 18'(req_payload.m22);
      comb[3] = 18'(req_payload.m22) - 18'(req_payload.m00) - 18'(req_payload.m11);
      best = comb[0];
      idx = COMP_W;
      if (comb[1] > best) begin
         best = comb[1];
         idx = COMP_X;
      end
      if (comb[2] > best) begin
         best = comb[2];
         idx = COMP_Y;
      end
      if (comb[3] > best) begin
         best = comb[3];
         idx = COMP_Z;
      end
      d_a = 17'(req_payload.m21) - 17'(req_payload.m12);
      d_b = 17'(req_payload.m02) - 17'(req_payload.m20);
      d_c = 17'(req_payload.m10) - 17'(req_payload.m01);
      s_a = 17'(req_payload.m21) + 17'(req_payload.m12);
      s_b = 17'(req_payload.m02) + 17'(req_payload.m20);
      s_c = 17'(req_payload.m10) + 17'(req_payload.m01);
      unique case (idx)
         COMP_W: begin
            dlane[0] = d_a; dlane[1] = d_b; dlane[2] = d_c;
         end
         COMP_X: begin
            dlane[0] = d_a; dlane[1] = s_c; dlane[2] = s_b;
         end
         COMP_Y: begin
            dlane[0] = d_b; dlane[1] = s_c; dlane[2] = s_a;
         end
         default: begin
            dlane[0] = d_c; dlane[1] = s_b; dlane[2] = s_a;
         end
      endcase
      rsum = best + 18'(1 << FRAC_BITS);
      sq_in.rem = '0;
      sq_in.root = '0;
      sq_in.rad = RAD_W'({rsum, {FRAC_BITS{1'b0}}});
      side_in.idx = idx;
      for (int k = 0; k < LANES; k++) begin
         side_in.neg[k] = dlane[k][MAG_W-1];
         side_in.mag[k] = dlane[k][MAG_W-1] ? MAG_W'(-dlane[k]) : MAG_W'(dlane[k]);
      end
   end

   // square root chain
   sq_type sq_q [SQ_N+1];
   sq_side_type sq_side_ff [SQ_N+1];
   logic [SQ_N:0] sq_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (adv) begin
         sq_valid_ff <= {sq_valid_ff[SQ_N-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_q[0] <= sq_in;
         sq_side_ff[0] <= side_in;
         for (int i = 1; i <= SQ_N; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < SQ_N; g++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock   (clock),
         .enable  (adv),
         .cell_i  (sq_q[g]),
         .cell_ff (sq_q[g+1])
      );
   end

   // divider chain
   dv_type dv_q [LANES][DV_N+1];
   dv_side_type dv_side_ff [DV_N+1];
   logic [DV_N:0] dv_valid_ff;
   dv_side_type dside_in;

   always_comb begin
      dside_in.idx = sq_side_ff[SQ_N].idx;
      dside_in.neg = sq_side_ff[SQ_N].neg;
      dside_in.big = sq_q[SQ_N].root[ROOT_W-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else if (adv) begin
         dv_valid_ff <= {dv_valid_ff[DV_N-1:0], sq_valid_ff[SQ_N]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= dside_in;
         for (int i = 1; i <= DV_N; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
         for (int k = 0; k < LANES; k++) begin
            dv_q[k][0].rem <= '0;
            dv_q[k][0].dq <= {sq_side_ff[SQ_N].mag[k], {(FRAC_BITS-2){1'b0}}};
         end
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      for (genvar g = 0; g < DV_N; g++) begin : g_dv
         rmq_div_cell u_cell (
            .clock   (clock),
            .enable  (adv),
            .divisor (dv_side_ff[g].big),
            .cell_i  (dv_q[k][g]),
            .cell_ff (dv_q[k][g+1])
         );
      end
   end

   // saturate and place
   logic signed [DATA_W-1:0] lq [LANES];
   logic signed [DATA_W-1:0] big_s;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         if (dv_side_ff[DV_N].neg[k]) begin
            if (dv_q[k][DV_N].dq > DVD_W'(32768)) begin
               lq[k] = 16'sh8000;
            end else begin
               lq[k] = DATA_W'(-dv_q[k][DV_N].dq);
            end
         end else begin
            if (dv_q[k][DV_N].dq > DVD_W'(32767)) begin
               lq[k] = 16'sh7fff;
            end else begin
               lq[k] = DATA_W'(dv_q[k][DV_N].dq);
            end
         end
      end
      big_s = DATA_W'(dv_side_ff[DV_N].big);
      rsp_in.largest_component = dv_side_ff[DV_N].idx;
      unique case (dv_side_ff[DV_N].idx)
         COMP_W: begin
            rsp_in.quat_w = big_s; rsp_in.quat_x = lq[0];
            rsp_in.quat_y = lq[1]; rsp_in.quat_z = lq[2];
         end
         COMP_X: begin
            rsp_in.quat_w = lq[0]; rsp_in.quat_x = big_s;
            rsp_in.quat_y = lq[1]; rsp_in.quat_z = lq[2];
         end
         COMP_Y: begin
            rsp_in.quat_w = lq[0]; rsp_in.quat_x = lq[1];
            rsp_in.quat_y = big_s; rsp_in.quat_z = lq[2];
         end
         default: begin
            rsp_in.quat_w = lq[0]; rsp_in.quat_x = lq[1];
            rsp_in.quat_y = lq[2]; rsp_in.quat_z = big_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid_ff[DV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
